[design/ocvsoc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocvsoc_pkg
// Shared constants, tables and stage bundles for the OCV to SOC interpolator.
// ----------------------------------------------------------------------------
package ocvsoc_pkg;

	localparam int TABLE_POINTS = 42;
	localparam int SEGMENTS     = TABLE_POINTS - 1;
	localparam int IDX_W        = $clog2(TABLE_POINTS);

	localparam int MV_W    = 16;
	localparam int SOC_W   = 14;
	localparam int DIFF_W  = 7;   // in-segment offset, at most the widest span (100 mV)
	localparam int DSX_W   = 9;   // charge step times 100, at most 400
	localparam int NUM_W   = 16;  // offset * step * 100, at most 40000
	localparam int RECIP_W = 14;  // floor(2^16 / span), span at least 6
	localparam int PROD_W  = NUM_W + RECIP_W;
	localparam int RECIP_SHIFT = 16;
	localparam int QUO_W   = 9;   // quotient never exceeds the charge step times 100

	localparam logic [MV_W-1:0]  MV_TOP    = 16'd4200;
	localparam logic [MV_W-1:0]  MV_BOTTOM = 16'd3000;
	localparam logic [SOC_W-1:0] SOC_FULL  = 14'd10000;
	localparam logic [6:0]       PCT_SCALE = 7'd100;

	localparam logic [12:0] OCV_MV [TABLE_POINTS] = '{
		13'd4200, 13'd4185, 13'd4170, 13'd4150, 13'd4125, 13'd4100, 13'd4075,
		13'd4050, 13'd4025, 13'd4000, 13'd3959, 13'd3949, 13'd3932, 13'd3923,
		13'd3912, 13'd3906, 13'd3898, 13'd3892, 13'd3882, 13'd3874, 13'd3859,
		13'd3839, 13'd3813, 13'd3777, 13'd3716, 13'd3690, 13'd3675, 13'd3660,
		13'd3645, 13'd3630, 13'd3610, 13'd3590, 13'd3565, 13'd3540, 13'd3510,
		13'd3480, 13'd3415, 13'd3350, 13'd3250, 13'd3150, 13'd3060, 13'd3000
	};

	localparam logic [6:0] OCV_PCT [TABLE_POINTS] = '{
		7'd100, 7'd98, 7'd97, 7'd96, 7'd93, 7'd91, 7'd89, 7'd87, 7'd84, 7'd82,
		7'd79,  7'd78, 7'd75, 7'd73, 7'd70, 7'd68, 7'd65, 7'd63, 7'd60, 7'd58,
		7'd55,  7'd52, 7'd49, 7'd47, 7'd44, 7'd41, 7'd38, 7'd35, 7'd31, 7'd28,
		7'd24,  7'd21, 7'd18, 7'd15, 7'd12, 7'd10, 7'd7,  7'd5,  7'd3,  7'd2,
		7'd1,   7'd0
	};

	// floor(65536 / span) for each segment, top segment first
	localparam logic [RECIP_W-1:0] SEG_RECIP [SEGMENTS] = '{
		14'd4369, 14'd4369, 14'd3276, 14'd2621, 14'd2621, 14'd2621, 14'd2621,
		14'd2621, 14'd2621, 14'd1598, 14'd6553, 14'd3855, 14'd7281, 14'd5957,
		14'd10922, 14'd8192, 14'd10922, 14'd6553, 14'd8192, 14'd4369, 14'd3276,
		14'd2520, 14'd1820, 14'd1074, 14'd2520, 14'd4369, 14'd4369, 14'd4369,
		14'd4369, 14'd3276, 14'd3276, 14'd2621, 14'd2621, 14'd2184, 14'd2184,
		14'd1008, 14'd1008, 14'd655,  14'd655,  14'd728,  14'd1092
	};

	typedef struct packed {
		logic lo;                 // at or below the bottom breakpoint
		logic hi;                 // at or above the top breakpoint
		logic [SOC_W-1:0]  base;  // lower point charge times 100
		logic [DIFF_W-1:0] span;  // segment width in mV
	} carry_t;

	typedef struct packed {
		logic en_a;
		logic en_b;
	} stage_en_t;

endpackage

[design/ocvsoc_seg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocvsoc_seg
// Breakpoint compare (stage 1) and segment select with table lookup (stage 2).
// ----------------------------------------------------------------------------
module ocvsoc_seg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ocvsoc_pkg::stage_en_t           en,
	input  logic                            v_s2,
	input  logic [ocvsoc_pkg::MV_W-1:0]     cell_mv,
	output logic [ocvsoc_pkg::DIFF_W-1:0]   diff_s2,
	output logic [ocvsoc_pkg::DSX_W-1:0]    dsx_s2,
	output logic [ocvsoc_pkg::RECIP_W-1:0]  recip_s2,
	output ocvsoc_pkg::carry_t              carry_s2
);
	import ocvsoc_pkg::*;

	logic [MV_W-1:0]     mv_s1;
	logic [SEGMENTS-1:0] ge_s1;
	logic                lo_s1;
	logic                hi_s1;
	logic [SEGMENTS-1:0] ge_d;
	logic [IDX_W-1:0]    seg;
	logic [IDX_W-1:0]    seg_lo;
	logic [MV_W-1:0]     diff_full;
	logic [6:0]          dpct;
	logic [12:0]         span_full;

	// ge_d[k]: voltage at or above the lower point of segment k
	always_comb begin
		for (int k = 0; k < SEGMENTS; k++) begin
			ge_d[k] = cell_mv >= {3'b000, OCV_MV[k + 1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_a) begin
			mv_s1 <= cell_mv;
			ge_s1 <= ge_d;
			lo_s1 <= cell_mv <= MV_BOTTOM;
			hi_s1 <= cell_mv >= MV_TOP;
		end
	end

	// first bracketing segment from the top
	always_comb begin
		seg = '0;
		for (int k = SEGMENTS - 1; k >= 0; k--) begin
			if (ge_s1[k]) begin
				seg = IDX_W'(k);
			end
		end
	end

	assign seg_lo    = seg + IDX_W'(1);
	assign diff_full = mv_s1 - {3'b000, OCV_MV[seg_lo]};
	assign dpct      = OCV_PCT[seg] - OCV_PCT[seg_lo];
	assign span_full = OCV_MV[seg] - OCV_MV[seg_lo];

	always_ff @(posedge clk) begin
		if (en.en_b) begin
			diff_s2       <= diff_full[DIFF_W-1:0];
			dsx_s2        <= DSX_W'(dpct * PCT_SCALE);
			recip_s2      <= SEG_RECIP[seg];
			carry_s2.lo   <= lo_s1;
			carry_s2.hi   <= hi_s1;
			carry_s2.base <= SOC_W'(OCV_PCT[seg_lo] * PCT_SCALE);
			carry_s2.span <= span_full[DIFF_W-1:0];
		end
	end

	a_offset_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !carry_s2.lo && !carry_s2.hi) |-> (diff_s2 <= carry_s2.span))
		else $error("segment offset exceeds span");

endmodule

[design/ocvsoc_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocvsoc_mul
// Numerator product (stage 3) and reciprocal quotient estimate (stage 4).
// ----------------------------------------------------------------------------
module ocvsoc_mul (
	input  logic                            clk,
	input  ocvsoc_pkg::stage_en_t           en,
	input  logic [ocvsoc_pkg::DIFF_W-1:0]   diff_s2,
	input  logic [ocvsoc_pkg::DSX_W-1:0]    dsx_s2,
	input  logic [ocvsoc_pkg::RECIP_W-1:0]  recip_s2,
	input  ocvsoc_pkg::carry_t              carry_s2,
	output logic [ocvsoc_pkg::NUM_W-1:0]    num_s4,
	output logic [ocvsoc_pkg::QUO_W-1:0]    qe_s4,
	output ocvsoc_pkg::carry_t              carry_s4
);
	import ocvsoc_pkg::*;

	logic [NUM_W-1:0]   num_s3;
	logic [RECIP_W-1:0] recip_s3;
	carry_t             carry_s3;
	logic [PROD_W-1:0]  prod;

	always_ff @(posedge clk) begin
		if (en.en_a) begin
			num_s3   <= NUM_W'(diff_s2 * dsx_s2);
			recip_s3 <= recip_s2;
			carry_s3 <= carry_s2;
		end
	end

	// estimate is the true quotient or one below it
	assign prod = num_s3 * recip_s3;

	always_ff @(posedge clk) begin
		if (en.en_b) begin
			num_s4   <= num_s3;
			qe_s4    <= prod[RECIP_SHIFT +: QUO_W];
			carry_s4 <= carry_s3;
		end
	end

endmodule

[design/ocvsoc_fix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocvsoc_fix
// Quotient correction, offset add and end-of-table saturation (stage 5).
// ----------------------------------------------------------------------------
module ocvsoc_fix (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           v_s4,
	input  logic [ocvsoc_pkg::NUM_W-1:0]   num_s4,
	input  logic [ocvsoc_pkg::QUO_W-1:0]   qe_s4,
	input  ocvsoc_pkg::carry_t             carry_s4,
	output logic [ocvsoc_pkg::SOC_W-1:0]   soc_s5
);
	import ocvsoc_pkg::*;

	logic [NUM_W-1:0] rem;
	logic [QUO_W-1:0] quo;
	logic [SOC_W-1:0] soc_d;

	assign rem = num_s4 - NUM_W'(qe_s4 * carry_s4.span);
	assign quo = (rem >= NUM_W'(carry_s4.span)) ? qe_s4 + QUO_W'(1) : qe_s4;

	always_comb begin
		if (carry_s4.lo) begin
			soc_d = '0;
		end else if (carry_s4.hi) begin
			soc_d = SOC_FULL;
		end else begin
			soc_d = carry_s4.base + SOC_W'(quo);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			soc_s5 <= soc_d;
		end
	end

	a_one_step_fix: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !carry_s4.lo && !carry_s4.hi)
			|-> (rem < (NUM_W'(carry_s4.span) << 1)))
		else $error("quotient estimate off by more than one");

endmodule

[design/ocv_to_soc_interpolator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocv_to_soc_interpolator_core
// Cell voltage (mV) to state of charge (0.01 %) by piecewise linear
// interpolation over a fixed 42-point open-circuit-voltage table.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  input   | in_valid / in_ready  | cell_mv[15:0]        unsigned
//  output  | out_valid / out_ready| soc_hundredths[13:0] unsigned
//
// One transaction per cycle sustained while out_ready stays high; each result
// passes the compare, select, multiply, reciprocal and correct stages in turn.
// Every stage holds its own valid bit; a stage moves whenever it is empty or
// the stage after it moves, so bubbles collapse and a stall at the output
// backs up one stage at a time without loss or repeat.
// arst_n clears all valid bits; payload registers are not reset.
//
module ocv_to_soc_interpolator_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ocvsoc_pkg::MV_W-1:0]        cell_mv,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ocvsoc_pkg::SOC_W-1:0]       soc_hundredths
);
	import ocvsoc_pkg::*;

	// stage valid bits and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	logic [DIFF_W-1:0]  diff_s2;
	logic [DSX_W-1:0]   dsx_s2;
	logic [RECIP_W-1:0] recip_s2;
	carry_t             carry_s2;
	logic [NUM_W-1:0]   num_s4;
	logic [QUO_W-1:0]   qe_s4;
	carry_t             carry_s4;
	logic [SOC_W-1:0]   soc_s5;

	stage_en_t seg_en;
	stage_en_t mul_en;

	// advance a stage when it is empty or its successor advances
	assign en5 = !v_s5 || out_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign in_ready       = en1;
	assign out_valid      = v_s5;
	assign soc_hundredths = soc_s5;

	assign seg_en = '{en_a: en1, en_b: en2};
	assign mul_en = '{en_a: en3, en_b: en4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stages 1-2: breakpoint compare, segment select and table lookup
	ocvsoc_seg u_seg (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (seg_en),
		.v_s2     (v_s2),
		.cell_mv  (cell_mv),
		.diff_s2  (diff_s2),
		.dsx_s2   (dsx_s2),
		.recip_s2 (recip_s2),
		.carry_s2 (carry_s2)
	);

	// stages 3-4: numerator and reciprocal multiply
	ocvsoc_mul u_mul (
		.clk      (clk),
		.en       (mul_en),
		.diff_s2  (diff_s2),
		.dsx_s2   (dsx_s2),
		.recip_s2 (recip_s2),
		.carry_s2 (carry_s2),
		.num_s4   (num_s4),
		.qe_s4    (qe_s4),
		.carry_s4 (carry_s4)
	);

	// stage 5: correct quotient, add base, saturate at table ends
	ocvsoc_fix u_fix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en5),
		.v_s4     (v_s4),
		.num_s4   (num_s4),
		.qe_s4    (qe_s4),
		.carry_s4 (carry_s4),
		.soc_s5   (soc_s5)
	);

	a_soc_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (soc_hundredths <= SOC_FULL))
		else $error("state of charge above full scale");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with first stage empty");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && en4) |=> v_s5)
		else $error("transaction lost between stage 4 and stage 5");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the OCV to SOC interpolator core. A local table
// lookup with integer interpolation predicts every result. A small tracker
// queues the predictions in transaction order and compares each output
// transaction with the oldest one. Directed edge voltages come first, then
// random voltages under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;

	import ocvsoc_pkg::*;

	localparam int NPTS        = 42;
	localparam int RAND_ITEMS  = 375;  // per idling phase, four phases
	localparam int HOLD_CYCLES = 300;  // long receiver hold-off
	localparam int DRAIN_WAIT  = 12;   // final watch for stray outputs after the five-stage pipeline drains

	// Open-circuit voltage breakpoints (mV) and charge (whole percent), top first.
	localparam int BREAK_MV [NPTS] = '{
		4200, 4185, 4170, 4150, 4125, 4100, 4075, 4050, 4025, 4000,
		3959, 3949, 3932, 3923, 3912, 3906, 3898, 3892, 3882, 3874,
		3859, 3839, 3813, 3777, 3716, 3690, 3675, 3660, 3645, 3630,
		3610, 3590, 3565, 3540, 3510, 3480, 3415, 3350, 3250, 3150,
		3060, 3000
	};
	localparam int BREAK_PCT [NPTS] = '{
		100, 98, 97, 96, 93, 91, 89, 87, 84, 82,
		79, 78, 75, 73, 70, 68, 65, 63, 60, 58,
		55, 52, 49, 47, 44, 41, 38, 35, 31, 28,
		24, 21, 18, 15, 12, 10, 7, 5, 3, 2,
		1, 0
	};

	// Predict the charge for each accepted voltage and hold the predictions
	// until the matching output transaction arrives.
	class soc_tracker;
		logic [SOC_W-1:0] pending_soc[$];
		int unsigned      mismatch_count;

		function new();
			mismatch_count = 0;
		endfunction

		function logic [SOC_W-1:0] soc_from_mv(logic [MV_W-1:0] mv);
			int unsigned v;
			int unsigned hi_mv;
			int unsigned lo_mv;
			int unsigned hi_pct;
			int unsigned lo_pct;
			int unsigned num;
			v = mv;
			if (v <= 3000)
				return '0;
			if (v >= 4200)
				return SOC_W'(10000);
			for (int k = 0; k < NPTS - 1; k++) begin
				hi_mv  = BREAK_MV[k];
				lo_mv  = BREAK_MV[k + 1];
				hi_pct = BREAK_PCT[k];
				lo_pct = BREAK_PCT[k + 1];
				// first bracketing segment from the top wins, both ends inclusive
				if (v >= lo_mv && v <= hi_mv) begin
					num = (v - lo_mv) * (hi_pct - lo_pct) * 100;
					return SOC_W'(lo_pct * 100 + num / (hi_mv - lo_mv));
				end
			end
			return '0;
		endfunction

		function void note_voltage(logic [MV_W-1:0] mv);
			pending_soc.push_back(soc_from_mv(mv));
		endfunction

		function void check_soc(logic [SOC_W-1:0] actual);
			logic [SOC_W-1:0] want;
			if (pending_soc.size() == 0) begin
				mismatch_count++;
				$display("%0t: soc_hundredths expected none actual %0d", $time, actual);
				return;
			end
			want = pending_soc.pop_front();
			if (actual !== want) begin
				mismatch_count++;
				$display("%0t: soc_hundredths expected %0d actual %0d", $time, want, actual);
			end
		endfunction

		function int outstanding();
			return pending_soc.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [MV_W-1:0]  cell_mv;
	logic             out_valid;
	logic             out_ready;
	logic [SOC_W-1:0] soc_hundredths;

	soc_tracker  soc_log;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	bit          hold_req;
	int unsigned hold_left;

	ocv_to_soc_interpolator_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cell_mv        (cell_mv),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.soc_hundredths (soc_hundredths)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#2ms;
		$display("ocv_to_soc_interpolator_core: mismatch");
		$finish;
	end

	// Offer one voltage; optionally drop valid for a random gap first, then
	// hold valid and payload until the transaction is taken. Called right
	// after a rising edge, so valid stays high across back-to-back items.
	task automatic offer_voltage(input logic [MV_W-1:0] mv);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		cell_mv  <= mv;
		// in_ready read here is the value before this edge's register updates
		do @(posedge clk); while (!in_ready);
		soc_log.note_voltage(mv);
	endtask

	// Drop valid and hold the sender until every prediction has been matched.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (soc_log.outstanding() != 0)
			@(posedge clk);
	endtask

	// Pick a random voltage, weighted toward the table range and its breakpoints.
	function automatic logic [MV_W-1:0] pick_voltage();
		int unsigned r;
		int          bp;
		r = $urandom_range(99);
		if (r < 55)
			return MV_W'($urandom_range(4199, 3001));
		if (r < 72) begin
			// land on or next to a breakpoint
			bp = BREAK_MV[$urandom_range(NPTS - 1)] + int'($urandom_range(2)) - 1;
			return MV_W'(bp);
		end
		if (r < 86)
			return MV_W'($urandom());   // full 16-bit range, exercises every bit
		if (r < 93)
			return MV_W'($urandom_range(3000, 0));
		return MV_W'($urandom_range(65535, 4200));
	endfunction

	// Receiver: check each output transaction, then choose the next ready.
	// A hold-off request keeps ready low for a counted stretch so the
	// pipeline fills and backs up to the input.
	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				soc_log.check_soc(soc_hundredths);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Sender: reset, directed corners, then random phases.
	initial begin
		logic [MV_W-1:0] corner_mv [$];
		int unsigned     idle_mix  [4];
		int unsigned     stall_mix [4];

		soc_log        = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		cell_mv        = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, both clamps, exact breakpoints (top
		// segment wins at a shared point), narrowest and widest segments.
		corner_mv = '{16'd0, 16'd65535, 16'd2999, 16'd3000, 16'd3001, 16'd4199,
			16'd4200, 16'd4201, 16'd32768, 16'd3813, 16'd3480, 16'd3959,
			16'd3949, 16'd3912, 16'd3909, 16'd3906, 16'd3777, 16'd3716,
			16'd3150, 16'd3061, 16'd3060, 16'd4000, 16'h5555, 16'hAAAA};
		foreach (corner_mv[i])
			offer_voltage(corner_mv[i]);

		// Pause the sender until everything directed has come back.
		wait_drained();
		@(posedge clk);

		idle_mix  = '{0, 69, 0, 38};
		stall_mix = '{0, 0, 69, 38};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_mix[ph];
			recv_stall_pct = stall_mix[ph];
			for (int n = 0; n < RAND_ITEMS; n++) begin
				// in the no-idle phase, stall the receiver for a long stretch
				// while the sender keeps offering, forcing input backpressure
				if (ph == 0 && n == 100)
					hold_req = 1'b1;
				// bursts without idling even in the idling phases
				if (ph != 0 && n % 100 == 50) begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				if (ph != 0 && n % 100 == 80) begin
					send_idle_pct  = idle_mix[ph];
					recv_stall_pct = stall_mix[ph];
				end
				offer_voltage(pick_voltage());
			end
			wait_drained();
			@(posedge clk);
		end

		// Watch a few more cycles for stray output transactions.
		recv_stall_pct = 0;
		repeat (DRAIN_WAIT) @(posedge clk);

		if (soc_log.mismatch_count == 0 && soc_log.outstanding() == 0)
			$display("ocv_to_soc_interpolator_core: match");
		else
			$display("ocv_to_soc_interpolator_core: mismatch");
		$finish;
	end

endmodule
